@@ rtl/fbpa_pkg.sv @@
// Shared constants, codes and interface types of the fixed block pool allocator.
package fbpa_pkg;

    localparam int ADDR_FIELD_W   = 32;
    localparam int SIZE_W         = 16;
    localparam int COUNT_W        = 7;
    localparam int INDEX_FIELD_W  = 6;
    localparam int STATUS_W       = 2;
    localparam int CFG_INDEX_W    = 2;
    localparam int CFG_DATA_W     = 32;
    localparam int IN_TDATA_W     = 32;
    localparam int OUT_TDATA_W    = 40;

    localparam int DEF_MAX_BLOCKS = 64;
    localparam int DEF_ADDR_WIDTH = 32;

    // The in-use map is stored as rows of ROW_W bits.
    localparam int ROW_W          = 8;
    localparam int BIT_W          = 3;

    localparam logic [ADDR_FIELD_W-1:0] BASE_RESET  = '0;
    localparam logic [SIZE_W-1:0]       SIZE_RESET  = SIZE_W'(1);
    localparam logic [COUNT_W-1:0]      COUNT_RESET = COUNT_W'(64);

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_ALLOC = 2'd2;
    localparam logic [STATUS_W-1:0] ST_OUTSIDE   = 2'd3;

    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    localparam logic [CFG_INDEX_W-1:0] CFG_BASE  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SIZE  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_COUNT = 2'd2;

    typedef struct packed {
        logic find;
        logic drop;
    } map_cmd_t;

    typedef struct packed {
        logic ready;
        logic done;
        logic hit;
    } map_rsp_t;

endpackage

@@ rtl/fbpa_div.sv @@
// Bit-serial restoring divider: one quotient bit per cycle.
module fbpa_div
    import fbpa_pkg::*;
#(
    parameter int ADDR_WIDTH = DEF_ADDR_WIDTH
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic [ADDR_WIDTH-1:0] dividend,
    input  logic [SIZE_W-1:0]     divisor,
    output logic                  done,
    output logic [ADDR_WIDTH-1:0] quotient
);

    localparam int SW = $clog2(ADDR_WIDTH + 1);

    logic                  busy_reg;
    logic                  done_reg;
    logic [SW-1:0]         step_reg;
    logic [SIZE_W-1:0]     rem_reg;
    logic [SIZE_W-1:0]     dvs_reg;
    logic [ADDR_WIDTH-1:0] dq_reg;

    logic [SIZE_W:0]       rem_shift;
    logic                  ge;

    // The dividend shifts out at the top while quotient bits shift in at the bottom.
    assign rem_shift = {rem_reg, dq_reg[ADDR_WIDTH-1]};
    assign ge        = rem_shift >= {1'b0, dvs_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            done_reg <= busy_reg && !start && (step_reg == SW'(1));
            if (start) begin
                busy_reg <= 1'b1;
                step_reg <= SW'(ADDR_WIDTH);
                rem_reg  <= '0;
                dvs_reg  <= divisor;
                dq_reg   <= dividend;
            end else if (busy_reg) begin
                rem_reg  <= ge ? SIZE_W'(rem_shift - {1'b0, dvs_reg}) : SIZE_W'(rem_shift);
                dq_reg   <= {dq_reg[ADDR_WIDTH-2:0], ge};
                step_reg <= step_reg - SW'(1);
                if (step_reg == SW'(1)) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    assign done     = done_reg;
    assign quotient = dq_reg;

endmodule

@@ rtl/fbpa_mul.sv @@
// Shift-add address generator: base plus index times block size, one index bit per cycle.
module fbpa_mul
    import fbpa_pkg::*;
#(
    parameter int ADDR_WIDTH = DEF_ADDR_WIDTH,
    parameter int IDX_W      = 6
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic [ADDR_WIDTH-1:0] base,
    input  logic [SIZE_W-1:0]     size,
    input  logic [IDX_W-1:0]      idx,
    output logic                  done,
    output logic [ADDR_WIDTH-1:0] product
);

    localparam int SW = $clog2(IDX_W + 1);

    logic                  busy_reg;
    logic                  done_reg;
    logic [SW-1:0]         step_reg;
    logic [ADDR_WIDTH-1:0] acc_reg;
    logic [ADDR_WIDTH-1:0] mcand_reg;
    logic [IDX_W-1:0]      mplier_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            done_reg <= busy_reg && !start && (step_reg == SW'(1));
            if (start) begin
                busy_reg   <= 1'b1;
                step_reg   <= SW'(IDX_W);
                acc_reg    <= base;
                mcand_reg  <= ADDR_WIDTH'(size);
                mplier_reg <= idx;
            end else if (busy_reg) begin
                if (mplier_reg[0]) begin
                    acc_reg <= acc_reg + mcand_reg;
                end
                mcand_reg  <= mcand_reg << 1;
                mplier_reg <= mplier_reg >> 1;
                step_reg   <= step_reg - SW'(1);
                if (step_reg == SW'(1)) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule

@@ rtl/fbpa_map.sv @@
// In-use bitmap held in a row memory, with clearing pass, first-fit row scan and bit release.
module fbpa_map
    import fbpa_pkg::*;
#(
    parameter int MAX_BLOCKS = DEF_MAX_BLOCKS,
    parameter int IDX_W      = 6,
    parameter int EC_W       = 7
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  map_cmd_t         cmd,
    input  logic [IDX_W-1:0] cmd_idx,
    input  logic [EC_W-1:0]  count,
    output map_rsp_t         rsp,
    output logic [IDX_W-1:0] rsp_idx
);

    localparam int ROWS  = (MAX_BLOCKS + ROW_W - 1) / ROW_W;
    localparam int RA_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int CMP_W = EC_W + 1;

    typedef enum logic [1:0] {
        M_CLEAR,
        M_IDLE,
        M_READ,
        M_CHECK
    } map_state_t;

    map_state_t       state_reg;
    logic [RA_W-1:0]  row_reg;
    logic [BIT_W-1:0] bit_reg;
    logic             drop_reg;
    logic             done_reg;
    logic             hit_reg;
    logic [IDX_W-1:0] idx_reg;

    logic [ROW_W-1:0] mem [ROWS];
    logic [ROW_W-1:0] rd_data_reg;

    logic             wr_en;
    logic [ROW_W-1:0] wr_data;
    logic [CMP_W-1:0] row_base;
    logic [ROW_W-1:0] vmask;
    logic [ROW_W-1:0] free;
    logic [BIT_W-1:0] pick;
    logic             last_row;
    logic             sel;

    always_comb begin
        row_base = CMP_W'(row_reg) << BIT_W;
        for (int k = 0; k < ROW_W; k++) begin
            vmask[k] = (row_base + CMP_W'(k)) < CMP_W'(count);
        end
        free = ~rd_data_reg & vmask;
        pick = '0;
        for (int k = ROW_W - 1; k >= 0; k--) begin
            if (free[k]) begin
                pick = BIT_W'(k);
            end
        end
        last_row = ((row_base + CMP_W'(ROW_W)) >= CMP_W'(count))
                   || (row_reg == RA_W'(ROWS - 1));
        sel = rd_data_reg[bit_reg];

        wr_en   = 1'b0;
        wr_data = '0;
        case (state_reg)
            M_CLEAR: begin
                wr_en = 1'b1;
            end
            M_CHECK: begin
                if (drop_reg) begin
                    wr_en   = sel;
                    wr_data = rd_data_reg & ~(ROW_W'(1) << bit_reg);
                end else begin
                    wr_en   = |free;
                    wr_data = rd_data_reg | (ROW_W'(1) << pick);
                end
            end
            default: begin
                wr_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[row_reg] <= wr_data;
        end
        rd_data_reg <= mem[row_reg];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= M_CLEAR;
            row_reg   <= '0;
            done_reg  <= 1'b0;
            hit_reg   <= 1'b0;
            drop_reg  <= 1'b0;
        end else begin
            done_reg <= (state_reg == M_CHECK) && (drop_reg || (|free) || last_row);
            case (state_reg)
                M_CLEAR: begin
                    if (row_reg == RA_W'(ROWS - 1)) begin
                        row_reg   <= '0;
                        state_reg <= M_IDLE;
                    end else begin
                        row_reg <= row_reg + RA_W'(1);
                    end
                end
                M_IDLE: begin
                    if (cmd.find) begin
                        row_reg   <= '0;
                        drop_reg  <= 1'b0;
                        state_reg <= M_READ;
                    end else if (cmd.drop) begin
                        row_reg   <= RA_W'(cmd_idx / ROW_W);
                        bit_reg   <= BIT_W'(cmd_idx % ROW_W);
                        drop_reg  <= 1'b1;
                        state_reg <= M_READ;
                    end
                end
                M_READ: begin
                    state_reg <= M_CHECK;
                end
                M_CHECK: begin
                    if (drop_reg) begin
                        hit_reg   <= sel;
                        state_reg <= M_IDLE;
                    end else if (|free) begin
                        hit_reg   <= 1'b1;
                        idx_reg   <= IDX_W'(row_base + CMP_W'(pick));
                        state_reg <= M_IDLE;
                    end else if (last_row) begin
                        hit_reg   <= 1'b0;
                        state_reg <= M_IDLE;
                    end else begin
                        row_reg   <= row_reg + RA_W'(1);
                        state_reg <= M_READ;
                    end
                end
                default: begin
                    state_reg <= M_IDLE;
                end
            endcase
        end
    end

    assign rsp.ready = (state_reg == M_IDLE);
    assign rsp.done  = done_reg;
    assign rsp.hit   = hit_reg;
    assign rsp_idx   = idx_reg;

endmodule

@@ rtl/fixed_block_pool_allocator_core.sv @@
// Top level of the fixed block pool allocator: configuration, sequencing and result register.
//
//   Channel  Direction  Payload
//   s_axis   in         tuser: req_type; tdata: release_address
//   m_axis   out        tuser: status; tdata: block_address, block_index, zero pad
//   cfg      in         cfg_index selects base, block size or block count
//
// A request scans the map memory one row of 8 blocks at a time, reading and then checking
// each row; on a hit it runs the serial address multiply, then hands the result on. A
// release runs the bit-serial divider and, for an index inside the pool, clears its bit
// in the map. After reset the map is cleared row by row with s_axis_tready low. A result
// waiting on m_axis does not block the next transfer in.
module fixed_block_pool_allocator_core
    import fbpa_pkg::*;
#(
    parameter int MAX_BLOCKS = DEF_MAX_BLOCKS,
    parameter int ADDR_WIDTH = DEF_ADDR_WIDTH
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // [31:0] release_address
    input  logic [0:0]             s_axis_tuser,   // [0] req_type
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // [31:0] block_address, [37:32] block_index
    output logic [STATUS_W-1:0]    m_axis_tuser    // [1:0] status
);

    localparam int IDX_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
    localparam int EC_W  = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FIND,
        S_MUL,
        S_DIV,
        S_REL,
        S_OUT
    } core_state_t;

    core_state_t              state_reg;
    logic [ADDR_FIELD_W-1:0]  base_reg;
    logic [SIZE_W-1:0]        size_reg;
    logic [COUNT_W-1:0]       count_reg;

    logic [STATUS_W-1:0]      res_status_reg;
    logic [ADDR_FIELD_W-1:0]  res_addr_reg;
    logic [INDEX_FIELD_W-1:0] res_index_reg;

    logic                     m_valid_reg;
    logic [STATUS_W-1:0]      m_status_reg;
    logic [ADDR_FIELD_W-1:0]  m_addr_reg;
    logic [INDEX_FIELD_W-1:0] m_index_reg;

    logic [SIZE_W-1:0]        eff_size;
    logic [EC_W-1:0]          count_ext;
    logic [EC_W-1:0]          eff_count;
    logic [ADDR_WIDTH-1:0]    base_a;
    logic [ADDR_WIDTH-1:0]    addr_a;
    logic                     below;
    logic                     s_accept;
    logic                     q_outside;

    map_cmd_t                 map_cmd;
    map_rsp_t                 map_rsp;
    logic [IDX_W-1:0]         map_idx;
    logic                     div_start;
    logic                     div_done;
    logic [ADDR_WIDTH-1:0]    div_quotient;
    logic                     mul_start;
    logic                     mul_done;
    logic [ADDR_WIDTH-1:0]    mul_product;

    always_comb begin
        eff_size  = (size_reg == '0) ? SIZE_W'(1) : size_reg;
        count_ext = EC_W'(count_reg);
        eff_count = (count_ext > EC_W'(MAX_BLOCKS)) ? EC_W'(MAX_BLOCKS) : count_ext;
        base_a    = ADDR_WIDTH'(base_reg);
        addr_a    = ADDR_WIDTH'(s_axis_tdata);
        below     = addr_a < base_a;
        q_outside = div_quotient >= ADDR_WIDTH'(eff_count);
    end

    assign s_axis_tready = (state_reg == S_IDLE) && map_rsp.ready;
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    assign map_cmd.find = s_accept && (s_axis_tuser[0] == REQ_ALLOC);
    assign map_cmd.drop = (state_reg == S_DIV) && div_done && !q_outside;
    assign div_start    = s_accept && (s_axis_tuser[0] == REQ_FREE) && !below;
    assign mul_start    = (state_reg == S_FIND) && map_rsp.done && map_rsp.hit;

    fbpa_map #(
        .MAX_BLOCKS(MAX_BLOCKS),
        .IDX_W     (IDX_W),
        .EC_W      (EC_W)
    ) u_map (
        .aclk   (aclk),
        .aresetn(aresetn),
        .cmd    (map_cmd),
        .cmd_idx(IDX_W'(div_quotient)),
        .count  (eff_count),
        .rsp    (map_rsp),
        .rsp_idx(map_idx)
    );

    fbpa_div #(
        .ADDR_WIDTH(ADDR_WIDTH)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .dividend(addr_a - base_a),
        .divisor (eff_size),
        .done    (div_done),
        .quotient(div_quotient)
    );

    fbpa_mul #(
        .ADDR_WIDTH(ADDR_WIDTH),
        .IDX_W     (IDX_W)
    ) u_mul (
        .aclk   (aclk),
        .aresetn(aresetn),
        .start  (mul_start),
        .base   (base_a),
        .size   (eff_size),
        .idx    (map_idx),
        .done   (mul_done),
        .product(mul_product)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg    <= BASE_RESET;
            size_reg    <= SIZE_RESET;
            count_reg   <= COUNT_RESET;
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_BASE:  base_reg  <= cfg_wdata;
                    CFG_SIZE:  size_reg  <= SIZE_W'(cfg_wdata);
                    CFG_COUNT: count_reg <= COUNT_W'(cfg_wdata);
                    default:   ;
                endcase
            end

            // In S_OUT the output register is reloaded below instead.
            if (m_valid_reg && m_axis_tready && (state_reg != S_OUT)) begin
                m_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE: begin
                    if (s_accept) begin
                        if (s_axis_tuser[0] == REQ_ALLOC) begin
                            state_reg <= S_FIND;
                        end else if (below) begin
                            res_status_reg <= ST_OUTSIDE;
                            res_addr_reg   <= '0;
                            res_index_reg  <= '0;
                            state_reg      <= S_OUT;
                        end else begin
                            state_reg <= S_DIV;
                        end
                    end
                end
                S_FIND: begin
                    if (map_rsp.done) begin
                        res_addr_reg <= '0;
                        if (map_rsp.hit) begin
                            res_status_reg <= ST_OK;
                            res_index_reg  <= INDEX_FIELD_W'(map_idx);
                            state_reg      <= S_MUL;
                        end else begin
                            res_status_reg <= ST_FULL;
                            res_index_reg  <= '0;
                            state_reg      <= S_OUT;
                        end
                    end
                end
                S_MUL: begin
                    if (mul_done) begin
                        res_addr_reg <= ADDR_FIELD_W'(mul_product);
                        state_reg    <= S_OUT;
                    end
                end
                S_DIV: begin
                    if (div_done) begin
                        res_addr_reg <= '0;
                        if (q_outside) begin
                            res_status_reg <= ST_OUTSIDE;
                            res_index_reg  <= '0;
                            state_reg      <= S_OUT;
                        end else begin
                            res_index_reg <= INDEX_FIELD_W'(div_quotient);
                            state_reg     <= S_REL;
                        end
                    end
                end
                S_REL: begin
                    if (map_rsp.done) begin
                        res_status_reg <= map_rsp.hit ? ST_OK : ST_NOT_ALLOC;
                        state_reg      <= S_OUT;
                    end
                end
                S_OUT: begin
                    // The result waits here until the output register is free.
                    if (!m_valid_reg || m_axis_tready) begin
                        m_valid_reg  <= 1'b1;
                        m_status_reg <= res_status_reg;
                        m_addr_reg   <= res_addr_reg;
                        m_index_reg  <= res_index_reg;
                        state_reg    <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tuser  = m_status_reg;
    assign m_axis_tdata  = {{(OUT_TDATA_W - ADDR_FIELD_W - INDEX_FIELD_W){1'b0}},
                            m_index_reg, m_addr_reg};

    // The map only answers a search or a release that the sequencer is waiting for.
    assert property (@(posedge aclk) disable iff (!aresetn)
        map_rsp.done |-> (state_reg == S_FIND || state_reg == S_REL))
        else $error("map response outside a map wait state");

    // A command reaches the map only while it is idle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (map_cmd.find || map_cmd.drop) |-> map_rsp.ready)
        else $error("map command while the map is busy");

    // The divider and multiplier finish only in their own wait states.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (!div_done || state_reg == S_DIV) && (!mul_done || state_reg == S_MUL))
        else $error("arithmetic unit finished in the wrong state");

endmodule
